// File: sv/tdfe_pkg.sv
// Shared constants and types for the tag-delimited frame extractor.
package tdfe_pkg;

    localparam int DEFAULT_FRAME_CAPACITY = 4095;

    localparam int START_LEN = 9;
    localparam int END_LEN   = 7;
    localparam int LEN_W     = 12;

    localparam logic [7:0] OPEN_TAG [START_LEN] = '{
        8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h53, 8'h45, 8'h4E, 8'h44
    };

    localparam logic [7:0] CLOSE_TAG [END_LEN] = '{
        8'h45, 8'h4E, 8'h44, 8'h53, 8'h45, 8'h4E, 8'h44
    };

    typedef struct packed {
        logic             valid;
        logic             has_byte;
        logic [7:0]       payload_byte;
        logic             frame_end;
        logic [LEN_W-1:0] frame_length;
        logic             overflow;
    } tdfe_result_t;

endpackage

// File: sv/tag_delimited_frame_extractor.sv
// Top level of the tag-delimited frame extractor: stream ports and result register.
//
// The block takes one received byte per item on the slave stream and hunts for the
// start tag "STARTSEND"; a byte that breaks the match restarts the hunt and is not
// retried as the first tag byte. Once the tag is seen it collects bytes through a
// seven-byte window and releases each byte leaving the window as payload, so the
// end tag "ENDSEND" is stripped. Completing the end tag yields a result with tlast
// set and the frame's payload length; that same result also carries the final
// payload byte when there is one. A frame that holds FRAME_CAPACITY bytes and gets
// one more gives an overflow result, drops that byte and the window, and hunts
// again. Rate: one item per clock cycle while the output register is not stalled;
// each result appears in the output register in the cycle after the item that
// caused it. The tag compare and window shift are combinational between the state
// registers and the output register, and the input stays ready while the output
// register is empty or is being taken in the same cycle.
module tag_delimited_frame_extractor
    import tdfe_pkg::*;
#(
    parameter int FRAME_CAPACITY = DEFAULT_FRAME_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] payload_byte, [19:8] frame_length, rest 0
    output logic        m_tlast,    // frame_end
    output logic [1:0]  m_tuser     // [0] has_byte, [1] overflow
);

    tdfe_result_t res;
    logic         step;

    logic             valid_reg, valid_next;
    logic             has_byte_reg;
    logic [7:0]       payload_reg;
    logic             frame_end_reg;
    logic [LEN_W-1:0] length_reg;
    logic             overflow_reg;

    // Accept while the output register is free or drains this cycle.
    assign s_tready = !valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    tdfe_core #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (s_tdata),
        .res     (res)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            // Load the new result, or empty the register if the item made none.
            valid_next = res.valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until a new result replaces it.
    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            has_byte_reg  <= res.has_byte;
            payload_reg   <= res.payload_byte;
            frame_end_reg <= res.frame_end;
            length_reg    <= res.frame_length;
            overflow_reg  <= res.overflow;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, length_reg, payload_reg};
    assign m_tlast  = frame_end_reg;
    assign m_tuser  = {overflow_reg, has_byte_reg};

endmodule

// File: sv/tdfe_core.sv
// Tag hunt, end-tag window and frame length count for one item per cycle.
module tdfe_core
    import tdfe_pkg::*;
#(
    parameter int FRAME_CAPACITY = DEFAULT_FRAME_CAPACITY
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   in_byte,
    output tdfe_result_t res
);

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int MC_W  = $clog2(START_LEN);

    logic             collecting_reg, collecting_next;
    logic [MC_W-1:0]  match_cnt_reg, match_cnt_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [7:0]       win_reg [END_LEN];
    logic [7:0]       win_next [END_LEN];

    logic             start_hit;
    logic             full;
    logic             ejected;
    logic             end_hit;
    logic             shift_en;
    logic [CNT_W-1:0] held_inc;
    logic [EXT_W-1:0] len_ext;

    always_comb
    begin
        for (int i = 0; i < END_LEN - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[END_LEN - 1] = in_byte;
    end

    assign start_hit = (in_byte == OPEN_TAG[match_cnt_reg]);
    assign full      = (held_reg >= CNT_W'(FRAME_CAPACITY));
    assign ejected   = (held_reg >= CNT_W'(END_LEN));
    assign held_inc  = held_reg + 1'b1;
    assign len_ext   = EXT_W'(held_inc) - EXT_W'(END_LEN);
    assign shift_en  = step && collecting_reg && !full;

    always_comb
    begin
        end_hit = (held_reg >= CNT_W'(END_LEN - 1));
        for (int i = 0; i < END_LEN; i++)
        begin
            if (win_next[i] != CLOSE_TAG[i])
            begin
                end_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        collecting_next = collecting_reg;
        match_cnt_next  = match_cnt_reg;
        held_next       = held_reg;
        res             = '0;
        if (step)
        begin
            if (!collecting_reg)
            begin
                if (start_hit)
                begin
                    if (match_cnt_reg == MC_W'(START_LEN - 1))
                    begin
                        collecting_next = 1'b1;
                        held_next       = '0;
                        match_cnt_next  = '0;
                    end
                    else
                    begin
                        match_cnt_next = match_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    match_cnt_next = '0;
                end
            end
            else if (full)
            begin
                collecting_next = 1'b0;
                held_next       = '0;
                match_cnt_next  = '0;
                res.valid       = 1'b1;
                res.overflow    = 1'b1;
            end
            else
            begin
                held_next = held_inc;
                if (end_hit)
                begin
                    collecting_next  = 1'b0;
                    held_next        = '0;
                    match_cnt_next   = '0;
                    res.valid        = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_length = len_ext[LEN_W-1:0];
                end
                if (ejected)
                begin
                    res.valid        = 1'b1;
                    res.has_byte     = 1'b1;
                    res.payload_byte = win_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            match_cnt_reg  <= '0;
            held_reg       <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            match_cnt_reg  <= match_cnt_next;
            held_reg       <= held_next;
        end
    end

    // Window contents are only read once the window has been filled with frame bytes.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// File: sv/tdfe_checker.sv
// Port-level checker for the tag-delimited frame extractor and its bind.
module tdfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A full, stalled output register blocks the input.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result register is stalled");

    // A new result follows an accepted item.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted item");

    // Overflow results carry nothing else.
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tlast && !m_tuser[0] && m_tdata == 24'd0)
        else $error("overflow result carries other fields");

    // Results that neither end a frame nor report overflow carry a payload byte and no length.
    a_plain_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast && !m_tuser[1] |-> m_tuser[0] && m_tdata[23:8] == 16'd0)
        else $error("mid-frame result without payload byte");

endmodule

bind tag_delimited_frame_extractor tdfe_checker u_tdfe_checker (.*);
